// ===== rtl/x86ofc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the x86 operand form checker: payload structs, method and
// byte-mode codes, operand kinds, register codes and mode tables. No dependencies.
package x86ofc_pkg;

  typedef enum logic [4:0] {
    CMD_NONE     = 5'd0,
    CMD_FIXEDREG = 5'd1,
    CMD_ST       = 5'd2,
    CMD_CONST1   = 5'd3,
    CMD_A        = 5'd4,
    CMD_C        = 5'd5,
    CMD_D        = 5'd6,
    CMD_E        = 5'd7,
    CMD_F        = 5'd8,
    CMD_G        = 5'd9,
    CMD_SI2      = 5'd10,
    CMD_I2       = 5'd11,
    CMD_SI       = 5'd12,
    CMD_I        = 5'd13,
    CMD_J        = 5'd14,
    CMD_M        = 5'd15,
    CMD_O        = 5'd16,
    CMD_R        = 5'd17,
    CMD_S        = 5'd18,
    CMD_X        = 5'd19,
    CMD_Y        = 5'd20,
    CMD_V        = 5'd21,
    CMD_W        = 5'd22
  } cmd_e;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_REG  = 3'd1;
  localparam logic [2:0] KIND_IMM  = 3'd2;
  localparam logic [2:0] KIND_MEM  = 3'd3;
  localparam logic [2:0] KIND_FAR  = 3'd4;

  localparam logic [5:0] REG_NONE  = 6'd0;
  localparam logic [5:0] REG_GP_LO = 6'd1;
  localparam logic [5:0] REG_GP_HI = 6'd8;
  localparam logic [5:0] REG_ESP   = 6'd5;
  localparam logic [5:0] REG_EBP   = 6'd6;
  localparam logic [5:0] REG_ESI   = 6'd7;
  localparam logic [5:0] REG_EDI   = 6'd8;
  localparam logic [5:0] REG_SEG_LO = 6'd9;
  localparam logic [5:0] REG_SEG_HI = 6'd14;
  localparam logic [5:0] REG_ST0   = 6'd15;
  localparam logic [5:0] REG_CR_LO = 6'd23;
  localparam logic [5:0] REG_CR_HI = 6'd30;
  localparam logic [5:0] REG_DR_LO = 6'd31;
  localparam logic [5:0] REG_DR_HI = 6'd38;

  localparam logic [5:0] BM_NONE  = 6'd0;
  localparam logic [5:0] BM_FIX_HI = 6'd34;
  localparam logic [5:0] BM_ST    = 6'd35;
  localparam logic [5:0] BM_ST0   = 6'd36;
  localparam logic [5:0] BM_B     = 6'd44;
  localparam logic [5:0] BM_W     = 6'd45;
  localparam logic [5:0] BM_D     = 6'd46;
  localparam logic [5:0] BM_V     = 6'd47;
  localparam logic [5:0] BM_P     = 6'd48;
  localparam logic [5:0] BM_S     = 6'd49;
  localparam logic [5:0] BM_Q     = 6'd50;
  localparam logic [5:0] BM_SR    = 6'd51;
  localparam logic [5:0] BM_DR    = 6'd52;
  localparam logic [5:0] BM_ER    = 6'd53;
  localparam logic [5:0] BM_BCD   = 6'd54;
  localparam logic [5:0] BM_2B    = 6'd55;
  localparam logic [5:0] BM_28B   = 6'd56;
  localparam logic [5:0] BM_108B  = 6'd57;
  localparam logic [5:0] BM_512B  = 6'd58;

  localparam logic [1:0] RW_LO8  = 2'd0;
  localparam logic [1:0] RW_HI8  = 2'd1;
  localparam logic [1:0] RW_LO16 = 2'd2;
  localparam logic [1:0] RW_F32  = 2'd3;

  typedef enum logic [2:0] {
    WC_LO8  = 3'd0,
    WC_HI8  = 3'd1,
    WC_LO16 = 3'd2,
    WC_F32  = 3'd3,
    WC_E    = 3'd4,
    WC_SEG  = 3'd5
  } wclass_e;

  typedef struct packed {
    logic [5:0] base;
    wclass_e    wc;
  } fixed_reg_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [5:0]  byte_mode;
    logic [2:0]  operand_kind;
    logic [5:0]  base_register;
    logic [5:0]  index_register;
    logic [1:0]  register_width;
    logic [31:0] immediate_value;
    logic [2:0]  immediate_bytes;
    logic [9:0]  memory_bytes;
  } in_item_t;

  typedef struct packed {
    logic matches_res;
    logic bad_mode;
  } out_item_t;

  localparam logic [63:0] ONE64 = 64'd1;

  function automatic logic [63:0] allowed_modes(input logic [4:0] cmd);
    logic [63:0] st;
    logic [63:0] bwdv;
    logic [63:0] bv;
    logic [63:0] res;
    st   = 64'h0000_0FF8_0000_0000;
    bwdv = (ONE64 << BM_B) | (ONE64 << BM_W) | (ONE64 << BM_D) | (ONE64 << BM_V);
    bv   = (ONE64 << BM_B) | (ONE64 << BM_V);
    case (cmd)
      CMD_ST:  res = st;
      CMD_A:   res = ONE64 << BM_P;
      CMD_E, CMD_V, CMD_W: res = bwdv | (ONE64 << BM_P);
      CMD_G, CMD_I2, CMD_I, CMD_R: res = bwdv;
      CMD_SI2: res = ONE64 << BM_B;
      CMD_SI:  res = (ONE64 << BM_B) | (ONE64 << BM_W) | (ONE64 << BM_V);
      CMD_J, CMD_O, CMD_X, CMD_Y: res = bv;
      CMD_M: begin
        res = (ONE64 << BM_NONE) | (ONE64 << BM_B) | (ONE64 << BM_W) |
              (ONE64 << BM_D) | (ONE64 << BM_Q) | (ONE64 << BM_P) |
              (ONE64 << BM_S) | (ONE64 << BM_SR) | (ONE64 << BM_DR) |
              (ONE64 << BM_ER) | (ONE64 << BM_BCD) | (ONE64 << BM_2B) |
              (ONE64 << BM_28B) | (ONE64 << BM_108B) | (ONE64 << BM_512B);
      end
      default: res = '1;
    endcase
    return res;
  endfunction

  function automatic fixed_reg_t fixed_reg(input logic [5:0] bm);
    fixed_reg_t f;
    case (bm)
      6'd1:  f = '{6'd1, WC_LO8};
      6'd2:  f = '{6'd1, WC_HI8};
      6'd3:  f = '{6'd1, WC_LO16};
      6'd4:  f = '{6'd1, WC_F32};
      6'd5:  f = '{6'd1, WC_E};
      6'd6:  f = '{6'd4, WC_LO8};
      6'd7:  f = '{6'd4, WC_HI8};
      6'd8:  f = '{6'd4, WC_LO16};
      6'd9:  f = '{6'd4, WC_F32};
      6'd10: f = '{6'd4, WC_E};
      6'd11: f = '{6'd2, WC_LO8};
      6'd12: f = '{6'd2, WC_HI8};
      6'd13: f = '{6'd2, WC_LO16};
      6'd14: f = '{6'd2, WC_F32};
      6'd15: f = '{6'd2, WC_E};
      6'd16: f = '{6'd3, WC_LO8};
      6'd17: f = '{6'd3, WC_HI8};
      6'd18: f = '{6'd3, WC_LO16};
      6'd19: f = '{6'd3, WC_F32};
      6'd20: f = '{6'd3, WC_E};
      6'd21: f = '{6'd7, WC_F32};
      6'd22: f = '{6'd7, WC_E};
      6'd23: f = '{6'd8, WC_F32};
      6'd24: f = '{6'd8, WC_E};
      6'd25: f = '{6'd5, WC_F32};
      6'd26: f = '{6'd5, WC_E};
      6'd27: f = '{6'd6, WC_F32};
      6'd28: f = '{6'd6, WC_E};
      6'd29: f = '{6'd10, WC_SEG};
      6'd30: f = '{6'd12, WC_SEG};
      6'd31: f = '{6'd9, WC_SEG};
      6'd32: f = '{6'd13, WC_SEG};
      6'd33: f = '{6'd14, WC_SEG};
      6'd34: f = '{6'd11, WC_SEG};
      default: f = '{6'd0, WC_SEG};
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/x86_operand_form_checker.sv =====
`timescale 1ns / 1ps
// Top level of the x86 operand form checker: input register, form check, result register.
// Depends on x86ofc_pkg.
// Two register stages, in_q then out_q; out_q loads only when the result can advance.
// Throughput: one operand per cycle unless out_ready_i stalls; an empty in_q still loads.
// Reset clears both valid bits; payload registers are not reset.
module x86_operand_form_checker
  import x86ofc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      in_vld_q, in_vld_d;
  in_item_t  in_q;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, res_d;
  logic      advance;

  logic [4:0]  cmd;
  logic [5:0]  bm, base, idx;
  logic [2:0]  kind, isz;
  logic [1:0]  w;
  logic [31:0] imm;
  logic [9:0]  ms;
  logic        bad, m;
  logic        fits_s8, fits_s16, imm_lt256, imm_lt64k, is_gp;
  logic        rm_ok, disp_ok, e_mem_ok, m_size_ok, size_bv, fixed_ok;
  fixed_reg_t  fr;
  logic [63:0] allowed;

  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;
  assign in_vld_d   = (in_valid_i && in_ready_o) ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d  = advance ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cmd  = in_q.command;
  assign bm   = in_q.byte_mode;
  assign kind = in_q.operand_kind;
  assign base = in_q.base_register;
  assign idx  = in_q.index_register;
  assign w    = in_q.register_width;
  assign imm  = in_q.immediate_value;
  assign isz  = in_q.immediate_bytes;
  assign ms   = in_q.memory_bytes;

  assign allowed   = allowed_modes(cmd);
  assign bad       = (cmd <= CMD_W) && !allowed[bm];
  assign fits_s8   = (&imm[31:7]) || !(|imm[31:7]);
  assign fits_s16  = (&imm[31:15]) || !(|imm[31:15]);
  assign imm_lt256 = !(|imm[31:8]);
  assign imm_lt64k = !(|imm[31:16]);
  assign is_gp     = (base >= REG_GP_LO) && (base <= REG_GP_HI);
  assign fr        = fixed_reg(bm);

  always_comb begin
    case (fr.wc)
      WC_LO8:  fixed_ok = (w == RW_LO8);
      WC_HI8:  fixed_ok = (w == RW_HI8);
      WC_LO16: fixed_ok = (w == RW_LO16);
      WC_F32:  fixed_ok = (w == RW_F32);
      WC_E:    fixed_ok = (w == RW_LO16) || (w == RW_F32);
      default: fixed_ok = 1'b1;
    endcase
    fixed_ok = fixed_ok && (kind == KIND_REG) && (bm != BM_NONE) && (bm <= BM_FIX_HI) &&
               (base == fr.base);
  end

  always_comb begin
    case (bm)
      BM_B:    rm_ok = (w == RW_LO8) || (w == RW_HI8);
      BM_W:    rm_ok = (w == RW_LO16);
      BM_D:    rm_ok = (w == RW_F32);
      BM_V:    rm_ok = (w == RW_LO16) || (w == RW_F32);
      default: rm_ok = 1'b0;
    endcase
    rm_ok = rm_ok && is_gp;
  end

  always_comb begin
    disp_ok = 1'b1;
    if (base == REG_NONE && isz != 3'd4) disp_ok = 1'b0;
    if (base == REG_EBP && isz == 3'd0) disp_ok = 1'b0;
    if (isz == 3'd0 && imm != 32'd0) disp_ok = 1'b0;
    if (isz == 3'd1 && !fits_s8) disp_ok = 1'b0;
    if (isz == 3'd2 && !fits_s16) disp_ok = 1'b0;
  end

  always_comb begin
    case (bm)
      BM_B:    e_mem_ok = (ms == 10'd1);
      BM_W:    e_mem_ok = (ms == 10'd2);
      BM_D:    e_mem_ok = (ms == 10'd4);
      BM_V:    e_mem_ok = (ms == 10'd2) || (ms == 10'd4);
      default: e_mem_ok = (ms == 10'd6);
    endcase
  end

  always_comb begin
    case (bm)
      BM_NONE:        m_size_ok = (ms == 10'd0);
      BM_B:           m_size_ok = (ms == 10'd1);
      BM_P:           m_size_ok = (ms == 10'd4) || (ms == 10'd6);
      BM_S:           m_size_ok = (ms == 10'd6);
      BM_SR:          m_size_ok = (ms == 10'd4);
      BM_DR:          m_size_ok = (ms == 10'd8);
      BM_ER, BM_BCD:  m_size_ok = (ms == 10'd10);
      BM_W, BM_2B:    m_size_ok = (ms == 10'd2);
      BM_D:           m_size_ok = (ms == 10'd4);
      BM_Q:           m_size_ok = (ms == 10'd8);
      BM_28B:         m_size_ok = (ms == 10'd28);
      BM_108B:        m_size_ok = (ms == 10'd108);
      default:        m_size_ok = (ms == 10'd512);
    endcase
  end

  assign size_bv = (bm == BM_B) ? (ms == 10'd1) : ((ms == 10'd2) || (ms == 10'd4));

  always_comb begin
    m = 1'b0;
    case (cmd)
      CMD_NONE, CMD_F: m = (kind == KIND_NONE);
      CMD_FIXEDREG:    m = fixed_ok;
      CMD_ST: begin
        m = (kind == KIND_REG) &&
            (base == ((bm == BM_ST) ? REG_ST0 : (REG_ST0 + (bm - BM_ST0))));
      end
      CMD_CONST1: m = (kind == KIND_IMM) && (imm == 32'd1) && (isz == 3'd1);
      CMD_A:      m = (kind == KIND_FAR);
      CMD_C:      m = (kind == KIND_REG) && (base >= REG_CR_LO) && (base <= REG_CR_HI);
      CMD_D:      m = (kind == KIND_REG) && (base >= REG_DR_LO) && (base <= REG_DR_HI);
      CMD_E, CMD_V, CMD_W: begin
        m = ((kind == KIND_REG) && rm_ok) ||
            ((kind == KIND_MEM) && disp_ok && e_mem_ok);
      end
      CMD_G, CMD_R: m = (kind == KIND_REG) && rm_ok;
      CMD_SI2:      m = (kind == KIND_IMM) && fits_s8;
      CMD_I2, CMD_I: begin
        if (bm == BM_B) begin
          m = imm_lt256 && ((cmd == CMD_I2) || (isz == 3'd1));
        end else if (bm == BM_W) begin
          m = imm_lt64k && ((cmd == CMD_I2) || (isz == 3'd2));
        end else if (bm == BM_D) begin
          m = (cmd == CMD_I2) || (isz == 3'd4);
        end else begin
          m = ((isz == 3'd2) && imm_lt64k) || (isz == 3'd4);
        end
        m = m && (kind == KIND_IMM);
      end
      CMD_SI: begin
        if (bm == BM_B) begin
          m = (isz == 3'd1) && fits_s8;
        end else if (bm == BM_W) begin
          m = (isz == 3'd2) && fits_s16;
        end else begin
          m = ((isz == 3'd2) && fits_s16) || (isz == 3'd4);
        end
        m = m && (kind == KIND_IMM);
      end
      CMD_J: begin
        if (bm == BM_B) begin
          m = (isz == 3'd1) && fits_s8;
        end else begin
          m = ((isz == 3'd2) && fits_s16) || (isz == 3'd4);
        end
        m = m && (kind == KIND_IMM);
      end
      CMD_M: m = (kind == KIND_MEM) && disp_ok && (idx != REG_ESP) && m_size_ok;
      CMD_O: begin
        m = (kind == KIND_MEM) && (base == REG_NONE) && (idx == REG_NONE) &&
            ((isz == 3'd2) || (isz == 3'd4)) && size_bv;
      end
      CMD_S: m = (kind == KIND_REG) && (base >= REG_SEG_LO) && (base <= REG_SEG_HI);
      CMD_X, CMD_Y: begin
        m = (kind == KIND_MEM) && (base == ((cmd == CMD_X) ? REG_ESI : REG_EDI)) &&
            (idx == REG_NONE) && (imm == 32'd0) && size_bv;
      end
      default: m = 1'b0;
    endcase
  end

  assign res_d.matches_res = m && !bad;
  assign res_d.bad_mode    = bad;

endmodule

// ===== tb/x86ofc_verdict_checker.sv =====
`timescale 1ns / 1ps
// Verdict checker for the x86 operand form checker: watches both channels,
// predicts each operand's verdict and compares it with the block's result.
// Depends on x86ofc_pkg.
module x86ofc_verdict_checker
  import x86ofc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic [5:0] REG_EAX = REG_GP_LO;
  localparam logic [5:0] REG_ECX = 6'd2;
  localparam logic [5:0] REG_EDX = 6'd3;
  localparam logic [5:0] REG_EBX = 6'd4;
  localparam logic [5:0] REG_ES  = REG_SEG_LO;
  localparam logic [5:0] REG_CS  = 6'd10;
  localparam logic [5:0] REG_SS  = 6'd11;
  localparam logic [5:0] REG_DS  = 6'd12;
  localparam logic [5:0] REG_FS  = 6'd13;
  localparam logic [5:0] REG_GS  = 6'd14;

  localparam logic [5:0] BM_EDX_WIDE = 6'd20;
  localparam logic [5:0] BM_ESI_FULL = 6'd21;
  localparam logic [5:0] BM_EBP_WIDE = 6'd28;
  localparam logic [5:0] BM_CS_SEG   = 6'd29;

  out_item_t expected_verdicts[$];
  int        mismatches = 0;

  function automatic logic fits_signed8(input logic [31:0] v);
    logic [31:0] t;
    t = v + 32'd128;
    return t < 32'd256;
  endfunction

  function automatic logic fits_signed16(input logic [31:0] v);
    logic [31:0] t;
    t = v + 32'd32768;
    return t < 32'd65536;
  endfunction

  function automatic logic mode_possible(input logic [4:0] cmd, input logic [5:0] bm);
    logic bwdv;
    bwdv = bm >= BM_B && bm <= BM_V;
    case (cmd)
      CMD_ST:                      return bm >= BM_ST && bm <= BM_ST0 + 6'd7;
      CMD_A:                       return bm == BM_P;
      CMD_E, CMD_V, CMD_W:         return bwdv || bm == BM_P;
      CMD_G, CMD_I2, CMD_I, CMD_R: return bwdv;
      CMD_SI2:                     return bm == BM_B;
      CMD_SI:                      return bm == BM_B || bm == BM_W || bm == BM_V;
      CMD_J, CMD_O, CMD_X, CMD_Y:  return bm == BM_B || bm == BM_V;
      CMD_M: return bm == BM_NONE || (bm >= BM_B && bm <= BM_512B && bm != BM_V);
      default:                     return 1'b1;
    endcase
  endfunction

  function automatic logic fixed_reg_fits(input logic [5:0] bm, input logic [2:0] kind,
                                          input logic [5:0] base, input logic [1:0] w);
    int unsigned slot;
    logic [5:0]  want;
    wclass_e     wc;
    if (kind != KIND_REG || bm == BM_NONE || bm > BM_FIX_HI) return 1'b0;
    if (bm <= BM_EDX_WIDE) begin
      slot = 32'(bm) - 32'd1;
      case (slot / 5)
        0:       want = REG_EAX;
        1:       want = REG_EBX;
        2:       want = REG_ECX;
        default: want = REG_EDX;
      endcase
      case (slot % 5)
        0:       wc = WC_LO8;
        1:       wc = WC_HI8;
        2:       wc = WC_LO16;
        3:       wc = WC_F32;
        default: wc = WC_E;
      endcase
    end else if (bm <= BM_EBP_WIDE) begin
      slot = 32'(bm - BM_ESI_FULL);
      case (slot / 2)
        0:       want = REG_ESI;
        1:       want = REG_EDI;
        2:       want = REG_ESP;
        default: want = REG_EBP;
      endcase
      wc = slot[0] ? WC_E : WC_F32;
    end else begin
      slot = 32'(bm - BM_CS_SEG);
      case (slot)
        0:       want = REG_CS;
        1:       want = REG_DS;
        2:       want = REG_ES;
        3:       want = REG_FS;
        4:       want = REG_GS;
        default: want = REG_SS;
      endcase
      wc = WC_SEG;
    end
    if (base != want) return 1'b0;
    case (wc)
      WC_LO8:  return w == RW_LO8;
      WC_HI8:  return w == RW_HI8;
      WC_LO16: return w == RW_LO16;
      WC_F32:  return w == RW_F32;
      WC_E:    return w == RW_LO16 || w == RW_F32;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic gp_reg_fits(input logic [5:0] bm, input logic [5:0] base,
                                       input logic [1:0] w);
    if (base < REG_GP_LO || base > REG_GP_HI) return 1'b0;
    case (bm)
      BM_B:    return w <= RW_HI8;
      BM_W:    return w == RW_LO16;
      BM_D:    return w == RW_F32;
      BM_V:    return w == RW_LO16 || w == RW_F32;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic displacement_fits(input in_item_t op);
    if (op.base_register == REG_NONE && op.immediate_bytes != 3'd4) return 1'b0;
    if (op.base_register == REG_EBP && op.immediate_bytes == 3'd0) return 1'b0;
    if (op.immediate_bytes == 3'd0 && op.immediate_value != 32'd0) return 1'b0;
    if (op.immediate_bytes == 3'd1 && !fits_signed8(op.immediate_value)) return 1'b0;
    if (op.immediate_bytes == 3'd2 && !fits_signed16(op.immediate_value)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic byte_or_wide_size(input logic [5:0] bm, input logic [9:0] ms);
    if (bm == BM_B) return ms == 10'd1;
    return ms == 10'd2 || ms == 10'd4;
  endfunction

  function automatic logic rm_form_fits(input in_item_t op);
    if (op.operand_kind == KIND_REG)
      return gp_reg_fits(op.byte_mode, op.base_register, op.register_width);
    if (op.operand_kind != KIND_MEM || !displacement_fits(op)) return 1'b0;
    case (op.byte_mode)
      BM_B:    return op.memory_bytes == 10'd1;
      BM_W:    return op.memory_bytes == 10'd2;
      BM_D:    return op.memory_bytes == 10'd4;
      BM_V:    return op.memory_bytes == 10'd2 || op.memory_bytes == 10'd4;
      default: return op.memory_bytes == 10'd6;
    endcase
  endfunction

  function automatic logic memory_form_fits(input in_item_t op);
    logic [9:0] ms;
    ms = op.memory_bytes;
    if (!displacement_fits(op) || op.index_register == REG_ESP) return 1'b0;
    case (op.byte_mode)
      BM_NONE:        return ms == 10'd0;
      BM_B:           return ms == 10'd1;
      BM_P:           return ms == 10'd4 || ms == 10'd6;
      BM_S:           return ms == 10'd6;
      BM_SR:          return ms == 10'd4;
      BM_DR:          return ms == 10'd8;
      BM_ER, BM_BCD:  return ms == 10'd10;
      BM_W, BM_2B:    return ms == 10'd2;
      BM_D:           return ms == 10'd4;
      BM_Q:           return ms == 10'd8;
      BM_28B:         return ms == 10'd28;
      BM_108B:        return ms == 10'd108;
      default:        return ms == 10'd512;
    endcase
  endfunction

  function automatic out_item_t predict_verdict(input in_item_t op);
    out_item_t   v;
    logic        fit;
    logic [5:0]  bm;
    logic [2:0]  kind;
    logic [5:0]  base;
    logic [31:0] imm;
    logic [2:0]  isz;
    v    = '0;
    fit  = 1'b0;
    bm   = op.byte_mode;
    kind = op.operand_kind;
    base = op.base_register;
    imm  = op.immediate_value;
    isz  = op.immediate_bytes;
    if (!mode_possible(op.command, bm)) begin
      v.bad_mode = 1'b1;
      return v;
    end
    case (op.command)
      CMD_NONE, CMD_F: fit = kind == KIND_NONE;
      CMD_FIXEDREG:    fit = fixed_reg_fits(bm, kind, base, op.register_width);
      CMD_ST: fit = kind == KIND_REG &&
                    base == REG_ST0 + (bm == BM_ST ? 6'd0 : bm - BM_ST0);
      CMD_CONST1: fit = kind == KIND_IMM && imm == 32'd1 && isz == 3'd1;
      CMD_A:      fit = kind == KIND_FAR;
      CMD_C:      fit = kind == KIND_REG && base >= REG_CR_LO && base <= REG_CR_HI;
      CMD_D:      fit = kind == KIND_REG && base >= REG_DR_LO && base <= REG_DR_HI;
      CMD_S:      fit = kind == KIND_REG && base >= REG_SEG_LO && base <= REG_SEG_HI;
      CMD_E, CMD_V, CMD_W: fit = rm_form_fits(op);
      CMD_G, CMD_R: fit = kind == KIND_REG && gp_reg_fits(bm, base, op.register_width);
      CMD_SI2:    fit = kind == KIND_IMM && fits_signed8(imm);
      CMD_I2, CMD_I: begin
        if (kind == KIND_IMM) begin
          if (bm == BM_B)
            fit = imm < 32'd256 && (op.command == CMD_I2 || isz == 3'd1);
          else if (bm == BM_W)
            fit = imm < 32'd65536 && (op.command == CMD_I2 || isz == 3'd2);
          else if (bm == BM_D)
            fit = op.command == CMD_I2 || isz == 3'd4;
          else
            fit = (isz == 3'd2 && imm < 32'd65536) || isz == 3'd4;
        end
      end
      CMD_SI: begin
        if (kind == KIND_IMM) begin
          if (bm == BM_B)      fit = isz == 3'd1 && fits_signed8(imm);
          else if (bm == BM_W) fit = isz == 3'd2 && fits_signed16(imm);
          else fit = (isz == 3'd2 && fits_signed16(imm)) || isz == 3'd4;
        end
      end
      CMD_J: begin
        if (kind == KIND_IMM) begin
          if (bm == BM_B) fit = isz == 3'd1 && fits_signed8(imm);
          else fit = (isz == 3'd2 && fits_signed16(imm)) || isz == 3'd4;
        end
      end
      CMD_M: fit = kind == KIND_MEM && memory_form_fits(op);
      CMD_O: fit = kind == KIND_MEM && base == REG_NONE && op.index_register == REG_NONE &&
                   (isz == 3'd2 || isz == 3'd4) && byte_or_wide_size(bm, op.memory_bytes);
      CMD_X, CMD_Y:
        fit = kind == KIND_MEM && base == (op.command == CMD_X ? REG_ESI : REG_EDI) &&
              op.index_register == REG_NONE && imm == 32'd0 &&
              byte_or_wide_size(bm, op.memory_bytes);
      default: fit = 1'b0;
    endcase
    v.matches_res = fit;
    return v;
  endfunction

  always @(posedge clk_i) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with none expected, actual %b", $time, out_data_i);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data_i.matches_res !== want.matches_res) begin
            $display("%0t: matches_res expected %b actual %b", $time,
                     want.matches_res, out_data_i.matches_res);
            mismatches++;
          end
          if (out_data_i.bad_mode !== want.bad_mode) begin
            $display("%0t: bad_mode expected %b actual %b", $time,
                     want.bad_mode, out_data_i.bad_mode);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_verdicts.push_back(predict_verdict(in_data_i));
      pending_o    <= expected_verdicts.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/x86_operand_form_checker_test.sv =====
`timescale 1ns / 1ps
// Top of the operand form checker bench: clock, reset, operand stimulus and
// result back-pressure, with the verdict checker beside the block.
// Depends on x86ofc_pkg, x86_operand_form_checker and x86ofc_verdict_checker.
module x86_operand_form_checker_test;
  import x86ofc_pkg::*;

  localparam int RANDOM_ITEMS = 830;
  localparam int QUIET_FROM   = 720;
  localparam int PAUSE_AT     = 450;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [4:0] CMD_UNUSED_TOP = 5'd31;
  localparam logic [2:0] KIND_UNUSED    = 3'd7;
  localparam logic [5:0] BM_UNUSED_TOP  = 6'd63;
  localparam logic [5:0] BM_EAX_WIDE    = 6'd5;
  localparam logic [5:0] REG_UNUSED_TOP = 6'd63;
  localparam logic [5:0] REG_SS         = 6'd11;
  localparam logic [5:0] REG_EBX        = 6'd4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int   fail_count;
  int   pending;
  int   sent_count  = 0;
  int   cycle_count = 0;
  logic quiet       = 1'b0;
  logic hold_done   = 1'b0;

  always #4 clk = ~clk;

  x86_operand_form_checker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  x86ofc_verdict_checker verdicts (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t form_operand(input logic [4:0] cmd, input logic [5:0] bm,
                                            input logic [2:0] kind, input logic [5:0] base,
                                            input logic [5:0] idx, input logic [1:0] w,
                                            input logic [31:0] imm, input logic [2:0] isz,
                                            input logic [9:0] ms);
    in_item_t op;
    op.command         = cmd;
    op.byte_mode       = bm;
    op.operand_kind    = kind;
    op.base_register   = base;
    op.index_register  = idx;
    op.register_width  = w;
    op.immediate_value = imm;
    op.immediate_bytes = isz;
    op.memory_bytes    = ms;
    return op;
  endfunction

  function automatic in_item_t random_operand();
    logic [4:0]  cmd;
    logic [5:0]  bm;
    logic [2:0]  kind;
    logic [5:0]  base;
    logic [5:0]  idx;
    logic [31:0] imm;
    logic [2:0]  isz;
    logic [9:0]  ms;
    cmd  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 22));
    bm   = 6'($urandom_range(0, 63));
    kind = 3'($urandom_range(0, 4));
    base = 6'($urandom_range(0, 39));
    case (cmd)
      CMD_NONE, CMD_F: kind = KIND_NONE;
      CMD_FIXEDREG: begin
        bm   = 6'($urandom_range(1, 34));
        kind = KIND_REG;
        base = 6'($urandom_range(1, 14));
      end
      CMD_ST: begin
        bm   = 6'($urandom_range(35, 43));
        kind = KIND_REG;
        base = 6'($urandom_range(15, 22));
      end
      CMD_CONST1: kind = KIND_IMM;
      CMD_A: begin
        bm   = BM_P;
        kind = KIND_FAR;
      end
      CMD_C: begin
        kind = KIND_REG;
        base = 6'($urandom_range(23, 30));
      end
      CMD_D: begin
        kind = KIND_REG;
        base = 6'($urandom_range(31, 38));
      end
      CMD_S: begin
        kind = KIND_REG;
        base = 6'($urandom_range(9, 14));
      end
      CMD_E, CMD_V, CMD_W: begin
        bm   = 6'($urandom_range(44, 48));
        kind = $urandom_range(0, 1) ? KIND_REG : KIND_MEM;
        base = 6'($urandom_range(0, 8));
      end
      CMD_G, CMD_R: begin
        bm   = 6'($urandom_range(44, 47));
        kind = KIND_REG;
        base = 6'($urandom_range(1, 8));
      end
      CMD_I2, CMD_I: begin
        bm   = 6'($urandom_range(44, 47));
        kind = KIND_IMM;
      end
      CMD_SI2: begin
        bm   = BM_B;
        kind = KIND_IMM;
      end
      CMD_SI: begin
        case ($urandom_range(0, 2))
          0:       bm = BM_B;
          1:       bm = BM_W;
          default: bm = BM_V;
        endcase
        kind = KIND_IMM;
      end
      CMD_J, CMD_O, CMD_X, CMD_Y: begin
        bm   = $urandom_range(0, 1) ? BM_B : BM_V;
        kind = (cmd == CMD_J) ? KIND_IMM : KIND_MEM;
        if (cmd == CMD_O) base = REG_NONE;
        if (cmd == CMD_X) base = REG_ESI;
        if (cmd == CMD_Y) base = REG_EDI;
      end
      CMD_M: begin
        bm = 6'($urandom_range(0, 15));
        if (bm != BM_NONE) bm = bm + BM_B - 6'd1;
        if (bm == BM_V) bm = BM_Q;
        kind = KIND_MEM;
        base = 6'($urandom_range(0, 8));
      end
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0) bm = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 4) == 0) kind = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) == 0) base = 6'($urandom_range(0, 63));
    idx = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : REG_NONE;
    case ($urandom_range(0, 7))
      0, 1:    imm = 32'd0;
      2:       imm = 32'd1;
      3:       imm = 32'($urandom_range(0, 255)) - 32'd128;
      4:       imm = 32'($urandom_range(0, 65535));
      5:       imm = $urandom();
      default: begin
        case ($urandom_range(0, 13))
          0:       imm = 32'hFFFF_FF80;
          1:       imm = 32'h0000_007F;
          2:       imm = 32'h0000_0080;
          3:       imm = 32'hFFFF_FF7F;
          4:       imm = 32'h0000_00FF;
          5:       imm = 32'h0000_0100;
          6:       imm = 32'h0000_7FFF;
          7:       imm = 32'h0000_8000;
          8:       imm = 32'hFFFF_8000;
          9:       imm = 32'hFFFF_7FFF;
          10:      imm = 32'h0000_FFFF;
          11:      imm = 32'h0001_0000;
          12:      imm = 32'hFFFF_FFFF;
          default: imm = 32'h8000_0000;
        endcase
      end
    endcase
    if ($urandom_range(0, 5) == 0) isz = 3'($urandom_range(0, 7));
    else begin
      case ($urandom_range(0, 3))
        0:       isz = 3'd0;
        1:       isz = 3'd1;
        2:       isz = 3'd2;
        default: isz = 3'd4;
      endcase
    end
    if ($urandom_range(0, 3) == 0) ms = 10'($urandom_range(0, 1023));
    else begin
      case ($urandom_range(0, 9))
        0:       ms = 10'd0;
        1:       ms = 10'd1;
        2:       ms = 10'd2;
        3:       ms = 10'd4;
        4:       ms = 10'd6;
        5:       ms = 10'd8;
        6:       ms = 10'd10;
        7:       ms = 10'd28;
        8:       ms = 10'd108;
        default: ms = 10'd512;
      endcase
    end
    return form_operand(cmd, bm, kind, base, idx, 2'($urandom_range(0, 3)), imm, isz, ms);
  endfunction

  task automatic offer_operand(input in_item_t op);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    offer_operand(form_operand(CMD_NONE, BM_NONE, KIND_NONE, REG_NONE, REG_NONE, RW_LO8,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_FIXEDREG, BM_EAX_WIDE, KIND_REG, REG_GP_LO, REG_NONE,
                               RW_LO16, 32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_FIXEDREG, BM_B, KIND_REG, REG_GP_LO, REG_NONE, RW_LO8,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_FIXEDREG, BM_FIX_HI, KIND_REG, REG_SS, REG_NONE, RW_HI8,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_ST, BM_ST, KIND_REG, REG_ST0, REG_NONE, RW_F32,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_ST, BM_ST0 + 6'd7, KIND_REG, REG_ST0 + 6'd7, REG_NONE,
                               RW_F32, 32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_ST, BM_B, KIND_REG, REG_ST0, REG_NONE, RW_F32,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_CONST1, BM_B, KIND_IMM, REG_NONE, REG_NONE, RW_LO8,
                               32'd1, 3'd1, 10'd0));
    offer_operand(form_operand(CMD_A, BM_P, KIND_FAR, REG_NONE, REG_NONE, RW_LO8,
                               32'hFFFF_FFFF, 3'd4, 10'd6));
    offer_operand(form_operand(CMD_C, BM_D, KIND_REG, REG_CR_HI, REG_NONE, RW_F32,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_D, BM_D, KIND_REG, REG_DR_LO, REG_NONE, RW_F32,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_E, BM_P, KIND_REG, REG_GP_LO, REG_NONE, RW_F32,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_E, BM_P, KIND_MEM, REG_NONE, REG_NONE, RW_LO8,
                               32'h1234_5678, 3'd4, 10'd6));
    offer_operand(form_operand(CMD_F, BM_UNUSED_TOP, KIND_NONE, REG_NONE, REG_NONE, RW_LO8,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_G, BM_B, KIND_REG, REG_GP_HI, REG_NONE, RW_HI8,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_SI2, BM_B, KIND_IMM, REG_NONE, REG_NONE, RW_LO8,
                               32'hFFFF_FF80, 3'd1, 10'd0));
    offer_operand(form_operand(CMD_I2, BM_W, KIND_IMM, REG_NONE, REG_NONE, RW_LO8,
                               32'h0000_FFFF, 3'd1, 10'd0));
    offer_operand(form_operand(CMD_SI, BM_V, KIND_IMM, REG_NONE, REG_NONE, RW_LO8,
                               32'h0000_7FFF, 3'd2, 10'd0));
    offer_operand(form_operand(CMD_I, BM_D, KIND_IMM, REG_NONE, REG_NONE, RW_LO8,
                               32'hFFFF_FFFF, 3'd4, 10'd0));
    offer_operand(form_operand(CMD_J, BM_B, KIND_IMM, REG_NONE, REG_NONE, RW_LO8,
                               32'h0000_007F, 3'd1, 10'd0));
    offer_operand(form_operand(CMD_M, BM_512B, KIND_MEM, REG_EBP, REG_NONE, RW_LO8,
                               32'hFFFF_FFFF, 3'd3, 10'd512));
    offer_operand(form_operand(CMD_O, BM_V, KIND_MEM, REG_NONE, REG_NONE, RW_LO8,
                               32'h0000_1000, 3'd4, 10'd4));
    offer_operand(form_operand(CMD_R, BM_D, KIND_REG, REG_EBX, REG_NONE, RW_F32,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_S, BM_D, KIND_REG, REG_SEG_HI, REG_NONE, RW_LO16,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_X, BM_B, KIND_MEM, REG_ESI, REG_NONE, RW_LO8,
                               32'd0, 3'd0, 10'd1));
    offer_operand(form_operand(CMD_Y, BM_V, KIND_MEM, REG_EDI, REG_NONE, RW_LO8,
                               32'd0, 3'd0, 10'd2));
    offer_operand(form_operand(CMD_V, BM_W, KIND_REG, REG_ESP, REG_NONE, RW_LO16,
                               32'd0, 3'd0, 10'd0));
    offer_operand(form_operand(CMD_W, BM_D, KIND_MEM, REG_ESP, REG_ESP, RW_LO8,
                               32'd0, 3'd1, 10'd4));
    offer_operand(form_operand(CMD_UNUSED_TOP, BM_UNUSED_TOP, KIND_UNUSED, REG_UNUSED_TOP,
                               REG_UNUSED_TOP, RW_F32, 32'hFFFF_FFFF, 3'd7, 10'd1023));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) drain_results();
      if (i == QUIET_FROM) quiet = 1'b1;
      offer_operand(random_operand());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/x86ofc_pkg.sv
rtl/x86_operand_form_checker.sv
tb/x86ofc_verdict_checker.sv
tb/x86_operand_form_checker_test.sv
